/* design/psre_pkg.sv */
// Package for the stored-deflate RGBA PNG encoder core.
// Holds the CRC-32 byte step and the fixed constants; no dependencies.
package psre_pkg;

  localparam int unsigned MAX_DIM_DEF = 16384;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD   = 17'd65521;
  localparam logic [15:0] BLOCK_MAX   = 16'd65535;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  // one byte through the reflected CRC-32
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
    end
    return x;
  endfunction

endpackage

/* design/png_stored_rgba_encoder_core.sv */
// Top level of the stored-deflate RGBA8 PNG encoder: one byte sequencer that
// shares a CRC-32 byte unit and an Adler-32 add/compare unit among its states.
// Depends on psre_pkg.
//
// Steps: an input byte is taken only in idle and passes through the raw and
// Adler states before the next is taken; the first byte of an image first
// computes the IDAT length and sends the header, a row start adds a filter
// byte, a new block its header, and the last byte of an image the trailer.
// Reset: rst_n synchronous active low; dimensions return to zero, image idle.
module png_stored_rgba_encoder_core
  import psre_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [14:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] sample_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // last_of_run
  output logic        out_tuser   // [0] file_done
);

  localparam logic [14:0] MAX_D = 15'(MAX_DIMENSION);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CALC = 7'b0000010,
    S_HDR  = 7'b0000100,
    S_BHDR = 7'b0001000,
    S_RAW  = 7'b0010000,
    S_ADL  = 7'b0100000,
    S_TAIL = 7'b1000000
  } state_t;

  state_t      state_r;
  logic [14:0] width_r, height_r;
  logic [31:0] crc_r, crc_nxt;
  logic [15:0] alow_r, ahigh_r;
  logic [16:0] rbc_r;
  logic [14:0] row_r;
  logic [15:0] bfill_r;
  logic [30:0] raw_left_r;
  logic        started_r;
  logic [7:0]  samp_r;
  logic        is_filt_r;
  logic        fin_r;
  logic [5:0]  idx_r;
  logic [1:0]  cstep_r;
  logic [30:0] raw_r;
  logic [15:0] q_r;
  logic [31:0] rem_r;
  logic [31:0] idat_len_r;

  logic        ov_r, olast_r, odone_r;
  logic [7:0]  obyte_r;

  logic [14:0] w_eff, h_eff;
  assign w_eff = (width_r  > MAX_D) ? MAX_D : width_r;
  assign h_eff = (height_r > MAX_D) ? MAX_D : height_r;
  logic dim_zero;
  assign dim_zero = (w_eff == '0) || (h_eff == '0);

  // block header fields
  logic        blk_final;
  logic [15:0] blk_len;
  assign blk_final = (raw_left_r <= 31'(BLOCK_MAX));
  assign blk_len   = blk_final ? raw_left_r[15:0] : BLOCK_MAX;

  logic [7:0] raw_byte;
  assign raw_byte = is_filt_r ? 8'h00 : samp_r;

  logic        row_end, fin_now;
  assign row_end = (rbc_r + 17'd1) >= {w_eff, 2'b00};
  assign fin_now = !is_filt_r && row_end && ({1'b0, row_r} + 16'd1 >= {1'b0, h_eff});

  // emit mux
  logic       em_req, em_crc, em_rst, em_last, em_done;
  logic [7:0] em_byte;
  logic [31:0] crc_out;
  assign crc_out = ~crc_r;

  always_comb begin
    em_req = 1'b0; em_crc = 1'b0; em_rst = 1'b0; em_last = 1'b0; em_done = 1'b0;
    em_byte = 8'h00;
    case (state_r)
      S_HDR: begin
        em_req = 1'b1;
        em_crc = (idx_r >= 6'd12 && idx_r <= 6'd28) || (idx_r >= 6'd37);
        em_rst = (idx_r == 6'd12) || (idx_r == 6'd37);
        case (idx_r)
          6'd0:  em_byte = 8'h89;
          6'd1:  em_byte = 8'h50;
          6'd2:  em_byte = 8'h4E;
          6'd3:  em_byte = 8'h47;
          6'd4:  em_byte = 8'h0D;
          6'd5:  em_byte = 8'h0A;
          6'd6:  em_byte = 8'h1A;
          6'd7:  em_byte = 8'h0A;
          6'd11: em_byte = 8'h0D;
          6'd12: em_byte = 8'h49;
          6'd13: em_byte = 8'h48;
          6'd14: em_byte = 8'h44;
          6'd15: em_byte = 8'h52;
          6'd18: em_byte = {1'b0, w_eff[14:8]};
          6'd19: em_byte = w_eff[7:0];
          6'd22: em_byte = {1'b0, h_eff[14:8]};
          6'd23: em_byte = h_eff[7:0];
          6'd24: em_byte = 8'h08;
          6'd25: em_byte = 8'h06;
          6'd29: em_byte = crc_out[31:24];
          6'd30: em_byte = crc_out[23:16];
          6'd31: em_byte = crc_out[15:8];
          6'd32: em_byte = crc_out[7:0];
          6'd33: em_byte = idat_len_r[31:24];
          6'd34: em_byte = idat_len_r[23:16];
          6'd35: em_byte = idat_len_r[15:8];
          6'd36: em_byte = idat_len_r[7:0];
          6'd37: em_byte = 8'h49;
          6'd38: em_byte = 8'h44;
          6'd39: em_byte = 8'h41;
          6'd40: em_byte = 8'h54;
          6'd41: em_byte = 8'h78;
          6'd42: em_byte = 8'h01;
          default: em_byte = 8'h00;
        endcase
      end
      S_BHDR: begin
        em_req = 1'b1;
        em_crc = 1'b1;
        case (idx_r)
          6'd0:    em_byte = {7'd0, blk_final};
          6'd1:    em_byte = blk_len[7:0];
          6'd2:    em_byte = blk_len[15:8];
          6'd3:    em_byte = ~blk_len[7:0];
          default: em_byte = ~blk_len[15:8];
        endcase
      end
      S_RAW: begin
        em_req  = 1'b1;
        em_crc  = 1'b1;
        em_byte = raw_byte;
        em_last = !is_filt_r && !fin_now;
      end
      S_TAIL: begin
        em_req = 1'b1;
        em_crc = (idx_r <= 6'd3) || (idx_r >= 6'd12 && idx_r <= 6'd15);
        em_rst = (idx_r == 6'd12);
        em_last = (idx_r == 6'd19);
        em_done = (idx_r == 6'd19);
        case (idx_r)
          6'd0:  em_byte = ahigh_r[15:8];
          6'd1:  em_byte = ahigh_r[7:0];
          6'd2:  em_byte = alow_r[15:8];
          6'd3:  em_byte = alow_r[7:0];
          6'd4:  em_byte = crc_out[31:24];
          6'd5:  em_byte = crc_out[23:16];
          6'd6:  em_byte = crc_out[15:8];
          6'd7:  em_byte = crc_out[7:0];
          6'd12: em_byte = 8'h49;
          6'd13: em_byte = 8'h45;
          6'd14: em_byte = 8'h4E;
          6'd15: em_byte = 8'h44;
          6'd16: em_byte = crc_out[31:24];
          6'd17: em_byte = crc_out[23:16];
          6'd18: em_byte = crc_out[15:8];
          6'd19: em_byte = crc_out[7:0];
          default: em_byte = 8'h00;
        endcase
      end
      default: em_req = 1'b0;
    endcase
  end

  logic em_ok, em_fire;
  assign em_ok   = !ov_r || out_tready;
  assign em_fire = em_req && em_ok;

  // shared CRC byte unit
  logic [31:0] crc_base;
  assign crc_base = em_rst ? CRC_INIT : crc_r;
  assign crc_nxt  = crc_byte(crc_base, em_byte);

  // shared Adler add/compare unit: low in RAW, high in ADL
  logic [16:0] ad_a, ad_sum, ad_red;
  assign ad_a   = (state_r == S_ADL) ? {1'b0, ahigh_r} : {1'b0, alow_r};
  assign ad_sum = ad_a + ((state_r == S_ADL) ? {1'b0, alow_r} : {9'd0, raw_byte});
  assign ad_red = (ad_sum >= ADLER_MOD) ? (ad_sum - ADLER_MOD) : ad_sum;

  // IDAT length helpers
  logic [31:0] raw_mul;
  assign raw_mul = 32'(h_eff) * 32'({w_eff, 2'b00} + 17'd1);
  logic [31:0] q0;
  assign q0 = ({1'b0, raw_r} + 32'(raw_r >> 16)) >> 16;
  logic [15:0] blocks;
  assign blocks = q_r + ((rem_r != '0) ? 16'd1 : 16'd0);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = odone_r;

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      width_r    <= '0;
      height_r   <= '0;
      crc_r      <= CRC_INIT;
      alow_r     <= 16'd1;
      ahigh_r    <= '0;
      rbc_r      <= '0;
      row_r      <= '0;
      bfill_r    <= '0;
      raw_left_r <= '0;
      started_r  <= 1'b0;
      is_filt_r  <= 1'b0;
      fin_r      <= 1'b0;
      idx_r      <= '0;
      cstep_r    <= '0;
      ov_r       <= 1'b0;
    end else begin
      if (em_fire) begin
        ov_r <= 1'b1;
        obyte_r <= em_byte;
        olast_r <= em_last;
        odone_r <= em_done;
        if (em_crc) crc_r <= crc_nxt;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end

      if (cfg_wr_en && (cfg_addr == REG_WIDTH || cfg_addr == REG_HEIGHT)) begin
        if (cfg_addr == REG_WIDTH) width_r <= cfg_wdata;
        else height_r <= cfg_wdata;
        crc_r      <= CRC_INIT;
        alow_r     <= 16'd1;
        ahigh_r    <= '0;
        rbc_r      <= '0;
        row_r      <= '0;
        bfill_r    <= '0;
        raw_left_r <= '0;
        started_r  <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire && !dim_zero) begin
            samp_r    <= in_tdata;
            is_filt_r <= (rbc_r == '0);
            idx_r     <= '0;
            cstep_r   <= '0;
            if (!started_r) state_r <= S_CALC;
            else if (bfill_r == '0) state_r <= S_BHDR;
            else state_r <= S_RAW;
          end
        end
        S_CALC: begin
          case (cstep_r)
            2'd0: begin
              raw_r   <= raw_mul[30:0];
              cstep_r <= 2'd1;
            end
            2'd1: begin
              q_r     <= q0[15:0];
              cstep_r <= 2'd2;
            end
            2'd2: begin
              rem_r   <= {1'b0, raw_r} - (({16'd0, q_r} << 16) - {16'd0, q_r});
              cstep_r <= 2'd3;
            end
            default: begin
              if (rem_r >= {16'd0, BLOCK_MAX}) begin
                q_r   <= q_r + 16'd1;
                rem_r <= rem_r - {16'd0, BLOCK_MAX};
              end else begin
                idat_len_r <= 32'd6 + {1'b0, raw_r} + {14'd0, blocks, 2'b00}
                              + {16'd0, blocks};
                raw_left_r <= raw_r;
                started_r  <= 1'b1;
                state_r    <= S_HDR;
              end
            end
          endcase
        end
        S_HDR: begin
          if (em_fire) begin
            if (idx_r == 6'd42) begin
              idx_r   <= '0;
              state_r <= (bfill_r == '0) ? S_BHDR : S_RAW;
            end else begin
              idx_r <= idx_r + 6'd1;
            end
          end
        end
        S_BHDR: begin
          if (em_fire) begin
            if (idx_r == 6'd4) begin
              idx_r   <= '0;
              state_r <= S_RAW;
            end else begin
              idx_r <= idx_r + 6'd1;
            end
          end
        end
        S_RAW: begin
          if (em_fire) begin
            alow_r  <= ad_red[15:0];
            bfill_r <= (bfill_r + 16'd1 >= BLOCK_MAX) ? 16'd0 : bfill_r + 16'd1;
            if (raw_left_r != '0) raw_left_r <= raw_left_r - 31'd1;
            if (!is_filt_r) begin
              if (row_end) begin
                rbc_r <= '0;
                row_r <= row_r + 15'd1;
              end else begin
                rbc_r <= rbc_r + 17'd1;
              end
            end
            fin_r   <= fin_now;
            state_r <= S_ADL;
          end
        end
        S_ADL: begin
          ahigh_r <= ad_red[15:0];
          if (is_filt_r) begin
            is_filt_r <= 1'b0;
            idx_r     <= '0;
            state_r   <= (bfill_r == '0) ? S_BHDR : S_RAW;
          end else if (fin_r) begin
            idx_r   <= '0;
            state_r <= S_TAIL;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_TAIL: begin
          if (em_fire) begin
            if (idx_r == 6'd19) begin
              alow_r     <= 16'd1;
              ahigh_r    <= '0;
              rbc_r      <= '0;
              row_r      <= '0;
              bfill_r    <= '0;
              raw_left_r <= '0;
              started_r  <= 1'b0;
              crc_r      <= CRC_INIT;
              state_r    <= S_IDLE;
            end else begin
              idx_r <= idx_r + 6'd1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("file_done without last_of_run");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    bfill_r < BLOCK_MAX)
    else $error("block fill out of range");

  a_adler_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, alow_r} < ADLER_MOD && {1'b0, ahigh_r} < ADLER_MOD)
    else $error("adler sum not reduced");

  a_tail_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TAIL && idx_r == 6'd19 && em_fire |=> out_tuser && !started_r)
    else $error("image not closed after trailer");
`endif

endmodule
